// ===== hdl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Request and result structs, the queued entry between front and back,
// result kind codes, hex digit decode and UTF-8 encoding.
// ---------------------------------------------------------------------------
package jsu_pkg;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } result_t;

    // One request's worth of results: count of 0 to 3, common kind, bytes.
    typedef struct packed {
        logic [1:0]      count;
        logic [1:0]      kind;
        logic [2:0][7:0] bytes;
    } entry_t;

    // Bit 4 set marks a byte that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (b >= 8'h30 && b <= 8'h39) begin
                d = b - 8'h30;
            end else if (b >= 8'h61 && b <= 8'h66) begin
                d = b - 8'h57;
            end else if (b >= 8'h41 && b <= 8'h46) begin
                d = b - 8'h37;
            end else begin
                d = 8'h10;
            end
            hex_value = d[4:0];
        end
    endfunction

    function automatic entry_t encode_utf8(input logic [15:0] code);
        entry_t e;
        begin
            e = '0;
            e.kind = KIND_BYTE;
            if (code <= 16'h007f) begin
                e.count    = 2'd1;
                e.bytes[0] = code[7:0];
            end else if (code <= 16'h07ff) begin
                e.count    = 2'd2;
                e.bytes[0] = 8'hc0 | {3'b000, code[10:6]};
                e.bytes[1] = 8'h80 | {2'b00, code[5:0]};
            end else begin
                e.count    = 2'd3;
                e.bytes[0] = 8'he0 | {4'h0, code[15:12]};
                e.bytes[1] = 8'h80 | {2'b00, code[11:6]};
                e.bytes[2] = 8'h80 | {2'b00, code[5:0]};
            end
            encode_utf8 = e;
        end
    endfunction

endpackage

// ===== hdl/jsu_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jsu_front: request parser
// Tracks string, escape and hex state and turns each accepted request
// into one queue entry of zero to three results.
// ---------------------------------------------------------------------------
module jsu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  jsu_pkg::item_t  item,
    output logic            ent_push,
    output jsu_pkg::entry_t ent
);
    import jsu_pkg::*;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_reg, code_next;
    logic [4:0]  hx;
    logic [15:0] code_full;
    logic [7:0]  b;
    logic        err;

    assign b         = item.in_byte;
    assign hx        = hex_value(b);
    assign code_full = {code_reg[11:0], hx[3:0]};

    always_comb
    begin
        mode_next      = mode_reg;
        hex_count_next = hex_count_reg;
        code_next      = code_reg;
        ent            = '0;
        err            = 1'b0;
        if (fire) begin
            if (item.end_of_input) begin
                err = 1'b1;
            end else begin
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (b == CH_QUOTE) begin
                            mode_next      = MODE_STR;
                            hex_count_next = 2'd0;
                            code_next      = 16'd0;
                        end else begin
                            err = 1'b1;
                        end
                    end
                    MODE_STR:
                    begin
                        if (b == CH_QUOTE) begin
                            mode_next      = MODE_IDLE;
                            hex_count_next = 2'd0;
                            code_next      = 16'd0;
                            ent.count      = 2'd1;
                            ent.kind       = KIND_END;
                        end else if (b == CH_BSLASH) begin
                            mode_next = MODE_ESC;
                        end else begin
                            ent.count    = 2'd1;
                            ent.kind     = KIND_BYTE;
                            ent.bytes[0] = b;
                        end
                    end
                    MODE_ESC:
                    begin
                        mode_next = MODE_STR;
                        ent.count = 2'd1;
                        ent.kind  = KIND_BYTE;
                        unique case (b)
                            CH_SLASH, CH_BSLASH, CH_QUOTE: ent.bytes[0] = b;
                            CH_B: ent.bytes[0] = 8'h08;
                            CH_F: ent.bytes[0] = 8'h0c;
                            CH_N: ent.bytes[0] = 8'h0a;
                            CH_R: ent.bytes[0] = 8'h0d;
                            CH_T: ent.bytes[0] = 8'h09;
                            CH_U:
                            begin
                                ent            = '0;
                                mode_next      = MODE_HEX;
                                hex_count_next = 2'd0;
                                code_next      = 16'd0;
                            end
                            default: err = 1'b1;
                        endcase
                    end
                    MODE_HEX:
                    begin
                        if (hx[4]) begin
                            err = 1'b1;
                        end else if (hex_count_reg == 2'd3) begin
                            ent            = encode_utf8(code_full);
                            mode_next      = MODE_STR;
                            hex_count_next = 2'd0;
                            code_next      = 16'd0;
                        end else begin
                            code_next      = code_full;
                            hex_count_next = hex_count_reg + 2'd1;
                        end
                    end
                    default: err = 1'b1;
                endcase
            end
            if (err) begin
                ent            = '0;
                ent.count      = 2'd1;
                ent.kind       = KIND_ERR;
                mode_next      = MODE_IDLE;
                hex_count_next = 2'd0;
                code_next      = 16'd0;
            end
        end
    end

    assign ent_push = fire && (ent.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_IDLE;
            hex_count_reg <= 2'd0;
            code_reg      <= 16'd0;
        end else begin
            mode_reg      <= mode_next;
            hex_count_reg <= hex_count_next;
            code_reg      <= code_next;
        end
    end

endmodule

// ===== hdl/jsu_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jsu_fifo: entry queue between parser and result sequencer
// Short register queue that lets each side stall on its own.
// ---------------------------------------------------------------------------
module jsu_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  jsu_pkg::entry_t wr_data,
    output logic            q_full,
    input  logic            rd,
    output jsu_pkg::entry_t rd_data,
    output logic            q_empty
);
    import jsu_pkg::*;

    entry_t           mem [QDEPTH];
    logic [QAW-1:0]   wp_reg, rp_reg;
    logic [QAW:0]     cnt_reg;
    logic             do_wr, do_rd;

    assign q_full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_rd) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
        end
    end

endmodule

// ===== hdl/jsu_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jsu_back: result sequencer
// Holds one queued entry and hands out its results one per cycle while
// pop is high, marking the final one with last.
// ---------------------------------------------------------------------------
module jsu_back (
    input  logic             clk,
    input  logic             rst_n,
    input  jsu_pkg::entry_t  head,
    input  logic             q_empty,
    output logic             q_rd,
    output logic             empty,
    input  logic             pop,
    output jsu_pkg::result_t result
);
    import jsu_pkg::*;

    entry_t     cur_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       take, done, is_last;

    assign is_last = (idx_reg == cur_reg.count - 2'd1);
    assign take    = pop && valid_reg;
    assign done    = take && is_last;
    assign q_rd    = (!valid_reg || done) && !q_empty;
    assign empty   = !valid_reg;

    always_comb
    begin
        result.kind = cur_reg.kind;
        result.last = is_last;
        case (idx_reg)
            2'd0:    result.out_byte = cur_reg.bytes[0];
            2'd1:    result.out_byte = cur_reg.bytes[1];
            default: result.out_byte = cur_reg.bytes[2];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_rd) begin
            cur_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (q_rd) begin
                valid_reg <= 1'b1;
                idx_reg   <= 2'd0;
            end else if (done) begin
                valid_reg <= 1'b0;
                idx_reg   <= 2'd0;
            end else if (take) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

// ===== hdl/json_string_unescaper.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// json_string_unescaper: byte-serial unescaper for quoted JSON strings
// Parser front, four-entry queue and result sequencer back.
// ---------------------------------------------------------------------------
//  channel   handshake        payload
//  request   push / full      item   (in_byte, end_of_input)
//  result    pop / empty      result (out_byte, kind, last)
//
//  One request is taken per cycle while the queue has room; its results are
//  registered into the queue and then into the back sequencer before leaving.
//  The back sequencer emits one result per cycle while pop is high, so a \u
//  escape that expands to three bytes occupies it until all three are popped.
//  Reset clears parser state, queue pointers and the output valid.
//  A stall on pop fills the queue, then raises full.
// ---------------------------------------------------------------------------
module json_string_unescaper (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  jsu_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output jsu_pkg::result_t result
);
    import jsu_pkg::*;

    logic   fire, ent_push, q_rd, q_empty;
    entry_t ent, head;

    assign fire = push && !full;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item),
        .ent_push (ent_push),
        .ent      (ent)
    );

    jsu_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ent_push),
        .wr_data (ent),
        .q_full  (full),
        .rd      (q_rd),
        .rd_data (head),
        .q_empty (q_empty)
    );

    jsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.kind == KIND_BYTE || result.kind == KIND_END ||
                    result.kind == KIND_ERR))
        else $error("illegal result kind");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_BYTE) |-> (result.last && result.out_byte == 8'd0))
        else $error("end or error result not single and zero");

    a_full_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full while output idle");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && empty) |=> !empty)
        else $error("queued entry not loaded");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for json_string_unescaper
// Streams quoted strings into the unescaper: plain bytes, every simple
// escape, \u runs across all UTF-8 lengths, and broken or stray input. A
// scanner in the bench decodes each accepted request and queues the bytes,
// ends and errors it should produce. Each popped result is matched against
// the oldest queued one. Both sides idle at random; one stretch starves pop
// long enough to back the block up.
// ---------------------------------------------------------------------------
module tb;

    import jsu_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RANDOM_REQS = 215;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5c;
    localparam logic [7:0] CH_SLASH    = 8'h2f;
    localparam logic [7:0] CH_U        = 8'h75;

    typedef enum logic [1:0] {ST_IDLE, ST_STRING, ST_ESCAPE, ST_HEX} scan_state_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;

    result_t     pending_results[$];
    scan_state_t scan_state = ST_IDLE;
    logic [1:0]  digits_seen = 2'd0;
    logic [15:0] code_acc = 16'd0;

    logic [7:0] esc_letters[8] = '{CH_SLASH, CH_BSLASH, CH_QUOTE, "b", "f", "n", "r", "t"};

    int  cycles = 0;
    int  req_count = 0;
    int  bytes_seen = 0;
    int  ends_seen = 0;
    int  errs_seen = 0;
    int  fail_count = 0;
    int  pop_hold = 0;
    bit  no_gaps = 1'b0;

    json_string_unescaper uut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .empty (empty),
        .pop   (pop),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [4:0] digit_value(input logic [7:0] b);
        logic [4:0] v;
        begin
            v = 5'h10;
            if (b >= 8'h30 && b <= 8'h39)
                v = 5'(b - 8'h30);
            else if (b >= 8'h61 && b <= 8'h66)
                v = 5'(b - 8'h61 + 8'd10);
            else if (b >= 8'h41 && b <= 8'h46)
                v = 5'(b - 8'h41 + 8'd10);
            return v;
        end
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] b);
        bit hit;
        begin
            hit = (b == CH_U);
            for (int i = 0; i < 8; i++)
                if (esc_letters[i] == b)
                    hit = 1'b1;
            return hit;
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        begin
            if (nib < 4'd10)
                c = 8'h30 + 8'(nib);
            else if ($urandom_range(0, 1) == 0)
                c = 8'h41 + 8'(nib) - 8'd10;
            else
                c = 8'h61 + 8'(nib) - 8'd10;
            return c;
        end
    endfunction

    task automatic predict_unescape(input item_t req);
        logic [7:0] outb[3];
        logic [1:0] okind;
        logic [7:0] b;
        logic [4:0] dv;
        logic [15:0] cp;
        result_t r;
        int n;
        begin
            b = req.in_byte;
            n = 0;
            okind = KIND_BYTE;
            outb[0] = 8'h00;
            if (req.end_of_input)
            begin
                n = 1;
                okind = KIND_ERR;
            end
            else
            begin
                case (scan_state)
                    ST_IDLE:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            scan_state = ST_STRING;
                            digits_seen = 2'd0;
                            code_acc = 16'd0;
                        end
                        else
                        begin
                            n = 1;
                            okind = KIND_ERR;
                        end
                    end
                    ST_STRING:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            n = 1;
                            okind = KIND_END;
                        end
                        else if (b == CH_BSLASH)
                            scan_state = ST_ESCAPE;
                        else
                        begin
                            n = 1;
                            outb[0] = b;
                        end
                    end
                    ST_ESCAPE:
                    begin
                        n = 1;
                        scan_state = ST_STRING;
                        case (b)
                            CH_SLASH, CH_BSLASH, CH_QUOTE: outb[0] = b;
                            "b": outb[0] = 8'h08;
                            "f": outb[0] = 8'h0c;
                            "n": outb[0] = 8'h0a;
                            "r": outb[0] = 8'h0d;
                            "t": outb[0] = 8'h09;
                            CH_U:
                            begin
                                n = 0;
                                scan_state = ST_HEX;
                                digits_seen = 2'd0;
                                code_acc = 16'd0;
                            end
                            default: okind = KIND_ERR;
                        endcase
                    end
                    default:
                    begin
                        dv = digit_value(b);
                        if (dv[4])
                        begin
                            n = 1;
                            okind = KIND_ERR;
                        end
                        else
                        begin
                            code_acc = {code_acc[11:0], dv[3:0]};
                            if (digits_seen == 2'd3)
                            begin
                                cp = code_acc;
                                scan_state = ST_STRING;
                                digits_seen = 2'd0;
                                code_acc = 16'd0;
                                if (cp < 16'h0080)
                                begin
                                    n = 1;
                                    outb[0] = cp[7:0];
                                end
                                else if (cp < 16'h0800)
                                begin
                                    n = 2;
                                    outb[0] = {3'b110, cp[10:6]};
                                    outb[1] = {2'b10, cp[5:0]};
                                end
                                else
                                begin
                                    n = 3;
                                    outb[0] = {4'b1110, cp[15:12]};
                                    outb[1] = {2'b10, cp[11:6]};
                                    outb[2] = {2'b10, cp[5:0]};
                                end
                            end
                            else
                                digits_seen = digits_seen + 2'd1;
                        end
                    end
                endcase
            end
            if (okind != KIND_BYTE)
            begin
                outb[0] = 8'h00;
                scan_state = ST_IDLE;
                digits_seen = 2'd0;
                code_acc = 16'd0;
            end
            for (int i = 0; i < n; i++)
            begin
                r.out_byte = outb[i];
                r.kind = okind;
                r.last = (i == n - 1);
                pending_results.push_back(r);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            predict_unescape(item);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            case (result.kind)
                KIND_BYTE: bytes_seen++;
                KIND_END:  ends_seen++;
                default:   errs_seen++;
            endcase
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: out_byte %02h kind %0d last %0b",
                       result.out_byte, result.kind, result.last);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.out_byte !== want.out_byte)
                begin
                    $error("out_byte mismatch: expected %02h, got %02h",
                           want.out_byte, result.out_byte);
                    fail_count++;
                end
                if (result.kind !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, got %0d", want.kind, result.kind);
                    fail_count++;
                end
                if (result.last !== want.last)
                begin
                    $error("last mismatch: expected %0b, got %0b", want.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int gap;
        int n;
        pop <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        pop <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pop_hold > 0)
            begin
                n = pop_hold;
                pop_hold = 0;
                pop <= 1'b0;
                repeat (n) @(posedge clk);
                pop <= 1'b1;
            end
            else if (pop && !empty)
            begin
                gap = no_gaps ? 0 : $urandom_range(0, 5);
                if (gap > 0)
                begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                    pop <= 1'b1;
                end
            end
        end
    end

    task automatic send_req(input logic [7:0] b, input logic eoi);
        int gap;
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push <= 1'b1;
            item <= {b, eoi};
            do
                @(posedge clk);
            while (full);
            req_count++;
        end
    endtask

    task automatic send_char(input logic [7:0] b);
        send_req(b, 1'b0);
    endtask

    task automatic send_code(input logic [15:0] cp);
        begin
            send_char(CH_BSLASH);
            send_char(CH_U);
            for (int i = 3; i >= 0; i--)
                send_char(hex_char(cp[i * 4 +: 4]));
        end
    endtask

    task automatic send_breakage();
        logic [7:0] b;
        logic [4:0] dv;
        int k;
        begin
            case ($urandom_range(0, 3))
                0: send_req(8'($urandom_range(0, 255)), 1'b1);
                1:
                begin
                    send_char(CH_BSLASH);
                    do
                        b = 8'($urandom_range(0, 255));
                    while (is_escape_letter(b));
                    send_char(b);
                end
                2:
                begin
                    send_char(CH_BSLASH);
                    send_char(CH_U);
                    k = $urandom_range(0, 3);
                    repeat (k) send_char(hex_char(4'($urandom_range(0, 15))));
                    do
                    begin
                        b = 8'($urandom_range(0, 255));
                        dv = digit_value(b);
                    end
                    while (!dv[4]);
                    send_char(b);
                end
                default:
                begin
                    send_char(CH_BSLASH);
                    if ($urandom_range(0, 1) == 0)
                        send_char(CH_U);
                    send_req(8'($urandom_range(0, 255)), 1'b1);
                end
            endcase
        end
    endtask

    task automatic send_random_string(input bit broken);
        int n;
        int cut;
        logic [7:0] b;
        logic [15:0] cp;
        begin
            send_char(CH_QUOTE);
            n = $urandom_range(0, 6);
            cut = broken ? $urandom_range(0, n) : -1;
            for (int k = 0; k <= n; k++)
            begin
                if (k == cut)
                begin
                    send_breakage();
                    return;
                end
                if (k == n)
                    break;
                case ($urandom_range(0, 2))
                    0:
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == CH_QUOTE || b == CH_BSLASH);
                        send_char(b);
                    end
                    1:
                    begin
                        send_char(CH_BSLASH);
                        send_char(esc_letters[$urandom_range(0, 7)]);
                    end
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0: cp = 16'($urandom_range(0, 16'h007f));
                            1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
                            2: cp = 16'($urandom_range(16'h0800, 16'hffff));
                            default:
                            begin
                                case ($urandom_range(0, 6))
                                    0: cp = 16'h0000;
                                    1: cp = 16'h007f;
                                    2: cp = 16'h0080;
                                    3: cp = 16'h07ff;
                                    4: cp = 16'h0800;
                                    5: cp = 16'hd800;
                                    default: cp = 16'hffff;
                                endcase
                            end
                        endcase
                        send_code(cp);
                    end
                endcase
            end
            send_char(CH_QUOTE);
        end
    endtask

    task automatic test_idle_errors();
        begin
            send_char("x");
            send_req(8'hff, 1'b1);
        end
    endtask

    task automatic test_directed_string();
        begin
            send_char(CH_QUOTE);
            send_char(8'h00);
            send_char(8'hff);
            send_char(CH_BSLASH);
            send_char("t");
            send_code(16'h07ff);
            send_code(16'hffff);
            send_req(8'h00, 1'b1);
        end
    endtask

    task automatic test_bad_sequences();
        begin
            send_char(CH_QUOTE);
            send_char(CH_BSLASH);
            send_char("q");
            send_char(CH_QUOTE);
            send_char(CH_BSLASH);
            send_char(CH_U);
            send_char("1");
            send_char("g");
            send_char(CH_QUOTE);
            send_char(CH_QUOTE);
        end
    endtask

    task automatic test_random_strings();
        int stop_at;
        begin
            stop_at = req_count + RANDOM_REQS;
            while (req_count < stop_at)
            begin
                no_gaps = ($urandom_range(0, 5) == 0);
                case ($urandom_range(0, 9))
                    0:
                    begin
                        repeat ($urandom_range(1, 3))
                        begin
                            if ($urandom_range(0, 3) == 0)
                                send_req(8'($urandom_range(0, 255)), 1'b1);
                            else
                                send_char(8'($urandom_range(0, 8'h21)));
                        end
                    end
                    1, 2: send_random_string(1'b1);
                    default: send_random_string(1'b0);
                endcase
            end
            no_gaps = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        begin
            no_gaps = 1'b1;
            pop_hold = 60;
            send_char(CH_QUOTE);
            for (int k = 0; k < 24; k++)
                send_char(8'h61 + 8'(k));
            send_char(CH_QUOTE);
            no_gaps = 1'b0;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        item <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_errors();
        test_directed_string();
        test_bad_sequences();
        test_backpressure();
        test_random_strings();

        push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d requests: quoted strings, all escapes, \\u runs, broken input.",
                 req_count);
        $display("Checked %0d bytes, %0d string ends, %0d errors.",
                 bytes_seen, ends_seen, errs_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_fifo.sv
hdl/jsu_back.sv
hdl/json_string_unescaper.sv
sim/tb.sv
